### hw/rtl/midi_track_event_parser_defines.svh
// assertion macros for the midi track event parser
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define MTEP_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mtep assertion failed");
`define MTEP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtep implication failed");
`else
`define MTEP_ASSERT(label, expr)
`define MTEP_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

### hw/rtl/mtep_pkg.sv
// shared types and constants of the midi track event parser
package mtep_pkg;

  localparam int unsigned FRONT_DEPTH = 2;
  localparam int unsigned BACK_DEPTH  = 2;

  localparam logic [7:0] SYS_MASK     = 8'hF0;
  localparam logic [7:0] DATA_MASK    = 8'h7F;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] ST_PRESSURE  = 8'hD0;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_SYSEX   = 3'd1,
    KIND_META    = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_RUNNING = 2'd1,
    ERR_BAD_SYSTEM = 2'd2,
    ERR_TRUNCATED  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_SYXLEN,
    PH_METATYPE,
    PH_METALEN,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic is_status;
    logic is_channel;
    logic is_sysex;
    logic is_meta;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        track_start;
    logic        track_last;
    byte_class_t cls;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [31:0] event_length;
    logic [31:0] tick_time;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        end_of_track;
    err_t        error_code;
  } result_t;

endpackage

### hw/rtl/mtep_front.sv
// input queue of the parser: takes bytes and classifies them
module mtep_front import mtep_pkg::*; #(
  parameter int unsigned DEPTH = FRONT_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_track_start,
  input  logic       in_track_last,
  output logic       item_valid,
  output in_item_t   item,
  input  logic       item_take
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  in_item_t        mem_r [DEPTH];
  in_item_t        wr_item;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            wr_en, rd_en;

  always_comb begin
    wr_item.data_byte      = in_data_byte;
    wr_item.track_start    = in_track_start;
    wr_item.track_last     = in_track_last;
    wr_item.cls.is_status  = in_data_byte[7];
    wr_item.cls.is_channel = in_data_byte[7] && ((in_data_byte & SYS_MASK) != SYS_MASK);
    wr_item.cls.is_sysex   = (in_data_byte == ST_SYSEX) || (in_data_byte == ST_SYSEX_ESC);
    wr_item.cls.is_meta    = in_data_byte == ST_META;
  end

  assign full       = cnt_r == FULL_CNT;
  assign item_valid = cnt_r != '0;
  assign item       = mem_r[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

### hw/rtl/mtep_back.sv
// parser state machine and result queue
module mtep_back import mtep_pkg::*; #(
  parameter int unsigned DEPTH = BACK_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     item_take,
  output logic     res_valid,
  output result_t  res_head,
  input  logic     res_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [31:0] vlq_r, vlq_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [7:0]  fd_r, fd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        ended_r, ended_nxt;
  logic        err_r, err_nxt;

  // state seen by this item, cleared by track start
  phase_t      ph;
  logic [7:0]  rs, cs, fd, b;
  logic [31:0] vlq, tick, rem, vlq_shift;
  logic        ended, err, skip, early_fail, emit, fin, eot, meta;
  logic        rs_short, cs_short;
  result_t     res;

  // result queue
  result_t       q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          q_wr, q_rd;

  assign res_valid = cnt_r != '0;
  assign res_head  = q_r[rd_ptr_r];
  assign q_rd      = res_pop && res_valid;
  assign item_take = item_valid && ((cnt_r != FULL_CNT) || q_rd);
  assign q_wr      = item_take && emit;

  always_comb begin
    b     = item.data_byte;
    ph    = item.track_start ? PH_DELTA : phase_r;
    rs    = item.track_start ? 8'h00 : rs_r;
    vlq   = item.track_start ? 32'h0 : vlq_r;
    tick  = item.track_start ? 32'h0 : tick_r;
    cs    = item.track_start ? 8'h00 : cs_r;
    fd    = item.track_start ? 8'h00 : fd_r;
    rem   = item.track_start ? 32'h0 : rem_r;
    ended = item.track_start ? 1'b0 : ended_r;
    err   = item.track_start ? 1'b0 : err_r;

    phase_nxt = ph;
    rs_nxt    = rs;
    vlq_nxt   = vlq;
    tick_nxt  = tick;
    cs_nxt    = cs;
    fd_nxt    = fd;
    rem_nxt   = rem;
    ended_nxt = ended;
    err_nxt   = err;

    skip       = ended || err;
    early_fail = 1'b0;
    emit       = 1'b0;
    res        = '0;
    vlq_shift  = {vlq[24:0], b[6:0] & DATA_MASK[6:0]};
    rs_short   = ((rs & SYS_MASK) == ST_PROGRAM) || ((rs & SYS_MASK) == ST_PRESSURE);
    cs_short   = ((cs & SYS_MASK) == ST_PROGRAM) || ((cs & SYS_MASK) == ST_PRESSURE);
    fin        = rem[31:1] == '0;
    meta       = ph == PH_METALEN;
    eot        = 1'b0;

    if (!skip) begin
      case (ph)
        PH_DELTA: begin
          vlq_nxt = vlq_shift;
          if (!b[7]) begin
            tick_nxt  = tick + vlq_shift;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!item.cls.is_status) begin
            if (rs == 8'h00) begin
              early_fail       = 1'b1;
              emit             = 1'b1;
              err_nxt          = 1'b1;
              res.kind         = KIND_ERROR;
              res.error_code   = ERR_NO_RUNNING;
            end else begin
              cs_nxt = rs;
              fd_nxt = b;
              if (rs_short) begin
                emit             = 1'b1;
                res.kind         = KIND_CHANNEL;
                res.status       = rs;
                res.data_one     = b;
                res.event_length = 32'd2;
                vlq_nxt          = '0;
                phase_nxt        = PH_DELTA;
              end else begin
                phase_nxt = PH_DATA2;
              end
            end
          end else if (item.cls.is_channel) begin
            rs_nxt    = b;
            cs_nxt    = b;
            phase_nxt = PH_DATA1;
          end else if (item.cls.is_sysex) begin
            cs_nxt    = b;
            fd_nxt    = '0;
            vlq_nxt   = '0;
            phase_nxt = PH_SYXLEN;
          end else if (item.cls.is_meta) begin
            cs_nxt    = b;
            phase_nxt = PH_METATYPE;
          end else begin
            early_fail     = 1'b1;
            emit           = 1'b1;
            err_nxt        = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_BAD_SYSTEM;
          end
        end
        PH_DATA1: begin
          fd_nxt = b;
          if (cs_short) begin
            emit             = 1'b1;
            res.kind         = KIND_CHANNEL;
            res.status       = cs;
            res.data_one     = b;
            res.event_length = 32'd2;
            vlq_nxt          = '0;
            phase_nxt        = PH_DELTA;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit             = 1'b1;
          res.kind         = KIND_CHANNEL;
          res.status       = cs;
          res.data_one     = fd;
          res.data_two     = b;
          res.event_length = 32'd3;
          vlq_nxt          = '0;
          phase_nxt        = PH_DELTA;
        end
        PH_METATYPE: begin
          fd_nxt    = b;
          vlq_nxt   = '0;
          phase_nxt = PH_METALEN;
        end
        PH_SYXLEN, PH_METALEN: begin
          vlq_nxt = vlq_shift;
          if (!b[7]) begin
            eot              = meta && (fd == META_EOT) && (vlq_shift == '0);
            emit             = 1'b1;
            res.kind         = meta ? KIND_META : KIND_SYSEX;
            res.status       = cs;
            res.data_one     = fd;
            res.event_length = vlq_shift;
            res.end_of_track = eot;
            rem_nxt          = vlq_shift;
            if (eot) begin
              ended_nxt = 1'b1;
            end else if (vlq_shift == '0) begin
              phase_nxt = PH_DELTA;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          eot              = fin && (cs == ST_META) && (fd == META_EOT);
          emit             = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.status       = cs;
          res.data_one     = fd;
          res.event_length = vlq;
          res.payload_byte = b;
          res.payload_last = fin;
          res.end_of_track = eot;
          rem_nxt          = fin ? '0 : rem - 32'd1;
          if (eot) begin
            ended_nxt = 1'b1;
          end else if (fin) begin
            vlq_nxt   = '0;
            phase_nxt = PH_DELTA;
          end
        end
        default: begin
          phase_nxt = ph;
        end
      endcase

      // chunk ends before the end-of-track event completes
      if (!early_fail && item.track_last && !ended_nxt) begin
        emit           = 1'b1;
        err_nxt        = 1'b1;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_TRUNCATED;
      end
    end

    res.tick_time = tick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      rs_r    <= '0;
      vlq_r   <= '0;
      tick_r  <= '0;
      cs_r    <= '0;
      fd_r    <= '0;
      rem_r   <= '0;
      ended_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      vlq_r   <= vlq_nxt;
      tick_r  <= tick_nxt;
      cs_r    <= cs_nxt;
      fd_r    <= fd_nxt;
      rem_r   <= rem_nxt;
      ended_r <= ended_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (q_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(q_wr) - CW'(q_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

### hw/rtl/midi_track_event_parser.sv
// Top level of the MIDI track event parser. Bytes of one track chunk are pushed one per item
// and the block sustains one byte per clock cycle while full is low: a byte enters a
// FRONT_DEPTH-entry input queue, the parser takes one byte a cycle from it into a single
// state update while the result queue has room or is being popped, and any event it yields
// is written into a BACK_DEPTH-entry result queue on the edge that takes its last byte.
// full rises only when results are left waiting and both queues fill up. Channel events,
// sysex and meta headers, payload bytes and errors come out in byte order with their tick time.
`include "midi_track_event_parser_defines.svh"
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int unsigned FRONT_DEPTH_P = FRONT_DEPTH,
  parameter int unsigned BACK_DEPTH_P  = BACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  input  logic        in_track_last,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_status,
  output logic [7:0]  out_data_one,
  output logic [7:0]  out_data_two,
  output logic [31:0] out_event_length,
  output logic [31:0] out_tick_time,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_last,
  output logic        out_end_of_track,
  output logic [1:0]  out_error_code
);

  in_item_t item;
  logic     item_valid, item_take, res_valid;
  result_t  res_head;

  mtep_front #(.DEPTH(FRONT_DEPTH_P)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_track_start (in_track_start),
    .in_track_last  (in_track_last),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take)
  );

  mtep_back #(.DEPTH(BACK_DEPTH_P)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res_head   (res_head),
    .res_pop    (pop)
  );

  assign empty            = !res_valid;
  assign out_kind         = res_head.kind;
  assign out_status       = res_head.status;
  assign out_data_one     = res_head.data_one;
  assign out_data_two     = res_head.data_two;
  assign out_event_length = res_head.event_length;
  assign out_tick_time    = res_head.tick_time;
  assign out_payload_byte = res_head.payload_byte;
  assign out_payload_last = res_head.payload_last;
  assign out_end_of_track = res_head.end_of_track;
  assign out_error_code   = res_head.error_code;

  // parser never takes from an empty input queue
  `MTEP_ASSERT_IMPLY(a_take_valid, item_take, item_valid)
  // error items always carry a cause
  `MTEP_ASSERT_IMPLY(a_err_code, !empty && out_kind == KIND_ERROR, out_error_code != ERR_NONE)
  // end of track only on a meta header or its last payload byte
  `MTEP_ASSERT_IMPLY(a_eot_kind, !empty && out_end_of_track, out_kind == KIND_META || (out_kind == KIND_PAYLOAD && out_payload_last))

endmodule

### tb/midi_event_compare.sv
// predicts and checks the events of the midi track event parser from its two queue ports
`timescale 1ns / 1ps
module midi_event_compare import mtep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  input  logic        in_track_last,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_status,
  input  logic [7:0]  out_data_one,
  input  logic [7:0]  out_data_two,
  input  logic [31:0] out_event_length,
  input  logic [31:0] out_tick_time,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_payload_last,
  input  logic        out_end_of_track,
  input  logic [1:0]  out_error_code,
  output int          fail_count,
  output int          pending_events,
  output int          bytes_taken,
  output int          n_channel,
  output int          n_header,
  output int          n_payload,
  output int          n_error,
  output int          n_eot
);

  // parser state as the block should hold it
  phase_t      ph;
  logic [7:0]  run_st;
  logic [7:0]  cur_st;
  logic [7:0]  first_d;
  logic [31:0] vlq;
  logic [31:0] ticks;
  logic [31:0] remaining;
  logic        ended;
  logic        err_lat;

  result_t expected_events[$];

  task automatic clear_parser();
    ph        = PH_DELTA;
    run_st    = 8'h00;
    cur_st    = 8'h00;
    first_d   = 8'h00;
    vlq       = 32'h0;
    ticks     = 32'h0;
    remaining = 32'h0;
    ended     = 1'b0;
    err_lat   = 1'b0;
  endtask

  function automatic logic one_data_byte(input logic [7:0] st);
    return (st & SYS_MASK) == ST_PROGRAM || (st & SYS_MASK) == ST_PRESSURE;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [7:0] st,
                                          input logic [7:0] d1, input logic [7:0] d2,
                                          input logic [31:0] len, input logic [7:0] pb,
                                          input logic pl, input logic eot, input err_t err);
    result_t r;
    r.kind         = k;
    r.status       = st;
    r.data_one     = d1;
    r.data_two     = d2;
    r.event_length = len;
    r.tick_time    = ticks;
    r.payload_byte = pb;
    r.payload_last = pl;
    r.end_of_track = eot;
    r.error_code   = err;
    return r;
  endfunction

  // one byte into the parser; got says whether it yields an event
  task automatic parse_byte(input logic [7:0] b, input logic start, input logic last,
                            output logic got, output result_t r);
    logic fin;
    logic eot;
    logic meta;
    got = 1'b0;
    r = '0;
    if (start) clear_parser();
    if (ended || err_lat) return;
    case (ph)
      PH_DELTA: begin
        vlq = {vlq[24:0], b[6:0]};
        if (!b[7]) begin
          ticks = ticks + vlq;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (run_st == 8'h00) begin
            r = make_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00, 1'b0, 1'b0,
                            ERR_NO_RUNNING);
            got = 1'b1;
            err_lat = 1'b1;
          end else begin
            cur_st = run_st;
            first_d = b;
            if (one_data_byte(cur_st)) begin
              r = make_result(KIND_CHANNEL, cur_st, b, 8'h00, 32'd2, 8'h00, 1'b0, 1'b0,
                              ERR_NONE);
              got = 1'b1;
              vlq = 32'h0;
              ph = PH_DELTA;
            end else begin
              ph = PH_DATA2;
            end
          end
        end else if ((b & SYS_MASK) != SYS_MASK) begin
          run_st = b;
          cur_st = b;
          ph = PH_DATA1;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
          cur_st = b;
          first_d = 8'h00;
          vlq = 32'h0;
          ph = PH_SYXLEN;
        end else if (b == ST_META) begin
          cur_st = b;
          ph = PH_METATYPE;
        end else begin
          r = make_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00, 1'b0, 1'b0,
                          ERR_BAD_SYSTEM);
          got = 1'b1;
          err_lat = 1'b1;
        end
      end
      PH_DATA1: begin
        first_d = b;
        if (one_data_byte(cur_st)) begin
          r = make_result(KIND_CHANNEL, cur_st, b, 8'h00, 32'd2, 8'h00, 1'b0, 1'b0, ERR_NONE);
          got = 1'b1;
          vlq = 32'h0;
          ph = PH_DELTA;
        end else begin
          ph = PH_DATA2;
        end
      end
      PH_DATA2: begin
        r = make_result(KIND_CHANNEL, cur_st, first_d, b, 32'd3, 8'h00, 1'b0, 1'b0, ERR_NONE);
        got = 1'b1;
        vlq = 32'h0;
        ph = PH_DELTA;
      end
      PH_METATYPE: begin
        first_d = b;
        vlq = 32'h0;
        ph = PH_METALEN;
      end
      PH_SYXLEN, PH_METALEN: begin
        vlq = {vlq[24:0], b[6:0]};
        if (!b[7]) begin
          meta = (ph == PH_METALEN);
          eot = meta && first_d == META_EOT && vlq == 32'h0;
          r = make_result(meta ? KIND_META : KIND_SYSEX, cur_st, first_d, 8'h00, vlq, 8'h00,
                          1'b0, eot, ERR_NONE);
          got = 1'b1;
          remaining = vlq;
          if (eot) ended = 1'b1;
          else if (vlq == 32'h0) ph = PH_DELTA;
          else ph = PH_PAYLOAD;
        end
      end
      default: begin
        fin = remaining <= 32'd1;
        eot = fin && cur_st == ST_META && first_d == META_EOT;
        r = make_result(KIND_PAYLOAD, cur_st, first_d, 8'h00, vlq, b, fin, eot, ERR_NONE);
        got = 1'b1;
        remaining = fin ? 32'h0 : remaining - 32'd1;
        if (eot) begin
          ended = 1'b1;
        end else if (fin) begin
          vlq = 32'h0;
          ph = PH_DELTA;
        end
      end
    endcase
    // chunk ends before its end-of-track event: the truncation error replaces any event
    if (last && !ended && !err_lat) begin
      r = make_result(KIND_ERROR, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00, 1'b0, 1'b0,
                      ERR_TRUNCATED);
      got = 1'b1;
      err_lat = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] seen_v, inout logic bad);
    if (want_v !== seen_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, seen_v);
      bad = 1'b1;
    end
  endtask

  task automatic compare_event(input result_t want);
    logic bad;
    bad = 1'b0;
    check_field("kind", want.kind, out_kind, bad);
    check_field("status", want.status, out_status, bad);
    check_field("data_one", want.data_one, out_data_one, bad);
    check_field("data_two", want.data_two, out_data_two, bad);
    check_field("event_length", want.event_length, out_event_length, bad);
    check_field("tick_time", want.tick_time, out_tick_time, bad);
    check_field("payload_byte", want.payload_byte, out_payload_byte, bad);
    check_field("payload_last", want.payload_last, out_payload_last, bad);
    check_field("end_of_track", want.end_of_track, out_end_of_track, bad);
    check_field("error_code", want.error_code, out_error_code, bad);
    if (bad) fail_count++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    logic    got;
    if (!rst_n) begin
      clear_parser();
      expected_events.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $display("%0t ns: unexpected event, expected none, actual kind %0d tick %0h",
                   $time, out_kind, out_tick_time);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          compare_event(want);
          case (want.kind)
            KIND_CHANNEL:          n_channel++;
            KIND_SYSEX, KIND_META: n_header++;
            KIND_PAYLOAD:          n_payload++;
            default:               n_error++;
          endcase
          if (want.end_of_track) n_eot++;
        end
      end
      if (push && !full) begin
        parse_byte(in_data_byte, in_track_start, in_track_last, got, fresh);
        if (got) expected_events.insert(expected_events.size(), fresh);
        bytes_taken++;
      end
    end
    pending_events = expected_events.size();
  end

endmodule

### tb/tb_top.sv
// stimulus, clock, reset and verdict for the midi track event parser testbench
`timescale 1ns / 1ps
module tb_top;
  import mtep_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASE_BYTES  = 570;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 100;
  localparam int SETTLE       = 10;

  // known-good opening track: note on, running status, program change,
  // channel pressure, escaped sysex with an over-long length, end of track
  localparam int                 FIRST_LEN   = 25;
  localparam logic [8*25-1:0]    FIRST_TRACK = {
    8'h00, 8'h90, 8'h00, 8'h7F,
    8'h00, 8'h7F, 8'h00,
    8'h00, 8'hC0, 8'h05,
    8'h00, 8'hD3, 8'h40,
    8'h00, 8'hF7, 8'h90, 8'h80, 8'h80, 8'h80, 8'h01, 8'hFF,
    8'h00, 8'hFF, 8'h2F, 8'h00
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_track_start;
  logic        in_track_last;
  logic        empty;
  logic        pop;
  logic [2:0]  out_kind;
  logic [7:0]  out_status;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic [31:0] out_event_length;
  logic [31:0] out_tick_time;
  logic [7:0]  out_payload_byte;
  logic        out_payload_last;
  logic        out_end_of_track;
  logic [1:0]  out_error_code;

  int fail_count;
  int pending_events;
  int bytes_taken;
  int n_channel;
  int n_header;
  int n_payload;
  int n_error;
  int n_eot;

  int tx_idle_pct;
  int rx_idle_pct;
  int phase;
  int cycle_count;
  int tracks_sent;
  int bytes_queued;

  logic [7:0] trk[$];
  int         st_pos[$];

  midi_track_event_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_track_start   (in_track_start),
    .in_track_last    (in_track_last),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two),
    .out_event_length (out_event_length),
    .out_tick_time    (out_tick_time),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last),
    .out_end_of_track (out_end_of_track),
    .out_error_code   (out_error_code)
  );

  midi_event_compare compare_u (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_track_start   (in_track_start),
    .in_track_last    (in_track_last),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two),
    .out_event_length (out_event_length),
    .out_tick_time    (out_tick_time),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last),
    .out_end_of_track (out_end_of_track),
    .out_error_code   (out_error_code),
    .fail_count       (fail_count),
    .pending_events   (pending_events),
    .bytes_taken      (bytes_taken),
    .n_channel        (n_channel),
    .n_header         (n_header),
    .n_payload        (n_payload),
    .n_error          (n_error),
    .n_eot            (n_eot)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random pops, plus one long hold-off when the last phase begins
  initial begin : receiver
    int   hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // appends one byte to the track being built
  task automatic add_byte(input logic [7:0] b);
    trk.insert(trk.size(), b);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      in_data_byte <= 8'($urandom_range(0, 255));
      in_track_start <= 1'($urandom_range(0, 1));
      in_track_last <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_track_start <= s;
    in_track_last <= l;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_track(input logic with_start, input logic with_last);
    foreach (trk[i])
      send_byte(trk[i], with_start && i == 0, with_last && i == trk.size() - 1);
    tracks_sent++;
    bytes_queued += trk.size();
  endtask

  task automatic add_vlq(input logic [31:0] val, input int pad);
    logic [7:0]  enc[$];
    logic [31:0] rest;
    rest = val;
    enc.push_front({1'b0, rest[6:0]});
    rest = rest >> 7;
    while (rest != 0) begin
      enc.push_front({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    repeat (pad) enc.push_front(8'h80);
    foreach (enc[i]) add_byte(enc[i]);
  endtask

  // random content of a given byte count; five or more bytes can overflow 32 bits
  task automatic add_raw_vlq(input int n);
    logic [7:0] v;
    repeat (n - 1) begin
      v = 8'($urandom_range(0, 127));
      add_byte(v | 8'h80);
    end
    v = 8'($urandom_range(0, 127));
    add_byte(v);
  endtask

  task automatic add_delta();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) add_raw_vlq(1);
    else if (sel < 80) add_raw_vlq(2);
    else if (sel < 92) add_raw_vlq(3);
    else add_raw_vlq($urandom_range(4, 6));
  endtask

  task automatic add_length(input int n);
    int         sel;
    logic [7:0] v;
    sel = $urandom_range(0, 11);
    if (sel == 0 && n < 128) begin
      // high bits that fall off the top of the 32-bit value
      v = 8'($urandom_range(1, 7));
      add_byte(8'h80 | (v << 4));
      repeat (3) add_byte(8'h80);
      v = 8'(n);
      add_byte(v);
    end else if (sel == 1) begin
      add_vlq(n, $urandom_range(1, 3));
    end else begin
      add_vlq(n, 0);
    end
  endtask

  task automatic add_payload_event();
    int         plen;
    logic [7:0] v;
    if ($urandom_range(0, 29) == 0) begin
      // huge length: the rest of the chunk is swallowed as payload
      add_vlq($urandom, 0);
      plen = 3;
    end else begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      add_length(plen);
    end
    repeat (plen) begin
      v = 8'($urandom_range(0, 255));
      add_byte(v);
    end
  endtask

  task automatic build_track();
    int         sel;
    int         plen;
    logic [7:0] st;
    logic [7:0] v;
    logic       have_run;
    trk.delete();
    st_pos.delete();
    have_run = 1'b0;
    st = 8'h80;
    repeat ($urandom_range(1, 8)) begin
      add_delta();
      st_pos.insert(st_pos.size(), trk.size());
      sel = $urandom_range(0, 99);
      if (sel < 25 && have_run) begin
        v = 8'($urandom_range(0, 127));
        add_byte(v);
        if (st[7:4] != 4'hC && st[7:4] != 4'hD) begin
          v = 8'($urandom_range(0, 127));
          add_byte(v);
        end
      end else if (sel < 65) begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        have_run = 1'b1;
        add_byte(st);
        v = 8'($urandom_range(0, 127));
        add_byte(v);
        if (st[7:4] != 4'hC && st[7:4] != 4'hD) begin
          v = 8'($urandom_range(0, 127));
          add_byte(v);
        end
      end else if (sel < 78) begin
        add_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
        add_payload_event();
      end else begin
        add_byte(ST_META);
        v = 8'($urandom_range(0, 126));
        if (v >= META_EOT) v = v + 8'd1;
        add_byte(v);
        add_payload_event();
      end
    end
    add_delta();
    st_pos.insert(st_pos.size(), trk.size());
    add_byte(ST_META);
    add_byte(META_EOT);
    if ($urandom_range(0, 4) == 0) begin
      // end-of-track with payload completes on its last payload byte
      plen = $urandom_range(1, 3);
      add_vlq(plen, 0);
      repeat (plen) begin
        v = 8'($urandom_range(0, 255));
        add_byte(v);
      end
    end else begin
      add_byte(8'h00);
    end
  endtask

  task automatic random_track();
    int         sel;
    int         k;
    logic [7:0] v;
    logic       with_start;
    logic       with_last;
    build_track();
    with_start = 1'b1;
    with_last = 1'b1;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      k = $urandom_range(1, trk.size() - 1);
      while (trk.size() > k) v = trk.pop_back();
    end else if (sel < 19) begin
      v = 8'($urandom_range(8'hF1, 8'hFD));
      if (v >= ST_SYSEX_ESC) v = v + 8'd1;
      trk[st_pos[$urandom_range(0, st_pos.size() - 1)]] = v;
    end else if (sel < 24) begin
      v = 8'($urandom_range(0, 127));
      trk[st_pos[0]] = v;
    end else if (sel < 30) begin
      with_last = 1'b0;
    end else if (sel < 36) begin
      trk[$urandom_range(0, trk.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (sel < 39) begin
      with_start = 1'b0;
    end
    send_track(with_start, with_last);
    // stray bytes after a finished chunk are ignored
    if (sel >= 39 && sel < 42)
      repeat ($urandom_range(1, 4))
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int base;
    int drain;
    phase = 0;
    tx_idle_pct = 7;
    rx_idle_pct = 67;
    rst_n = 1'b0;
    push = 1'b0;
    in_data_byte = 8'h00;
    in_track_start = 1'b0;
    in_track_last = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    trk.delete();
    for (int i = 0; i < FIRST_LEN; i++) add_byte(FIRST_TRACK[8*(FIRST_LEN-1-i) +: 8]);
    send_track(1'b1, 1'b1);
    // single-byte chunk, bad system status, data byte with no running status
    trk.delete();
    add_byte(8'h00);
    send_track(1'b1, 1'b1);
    trk.delete();
    add_byte(8'h00);
    add_byte(8'hF4);
    send_track(1'b1, 1'b1);
    trk.delete();
    add_byte(8'h00);
    add_byte(8'h40);
    send_track(1'b1, 1'b1);

    for (int p = 0; p < 3; p++) begin
      phase = p;
      tx_idle_pct = (p == 0) ? 7 : (p == 1) ? 67 : 0;
      rx_idle_pct = (p == 0) ? 67 : (p == 1) ? 7 : 0;
      base = bytes_queued;
      while (bytes_queued - base < PHASE_BYTES) random_track();
    end
    push <= 1'b0;

    drain = 0;
    while (pending_events != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d bytes in %0d tracks, clean and broken, under three idling mixes",
             bytes_taken, tracks_sent);
    $display("events: %0d channel, %0d sysex/meta headers, %0d payload, %0d errors, %0d eot",
             n_channel, n_header, n_payload, n_error, n_eot);
    if (pending_events != 0) $display("%0d expected events never arrived", pending_events);
    if (fail_count == 0 && pending_events == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_front.sv
hw/rtl/mtep_back.sv
hw/rtl/midi_track_event_parser.sv
tb/midi_event_compare.sv
tb/tb_top.sv
